/* rtl/ctrl_pkg.sv */
// ----------------------------------------------------------------------------
// ctrl_pkg
// Shared types and constants of the hashed credential table: status codes,
// request kinds, sequencer states and the result record.
// ----------------------------------------------------------------------------
package ctrl_pkg;

  localparam logic [31:0] HASH_SEED    = 32'd5381;
  localparam int unsigned USER_COUNT_W = 7;
  localparam int unsigned STATUS_W     = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_TAKEN     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_WRONG_PW  = 3'd5
  } status_e;

  typedef enum logic {
    ACT_REGISTER = 1'b0,
    ACT_LOGIN    = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RD_ENTRY,
    S_CMP_LEN,
    S_CMP_BYTE,
    S_MISS,
    S_WRITE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                    ok;
    status_e                 status;
    logic [USER_COUNT_W-1:0] user_count;
  } result_t;

endpackage

/* rtl/ctrl_if.sv */
// ----------------------------------------------------------------------------
// ctrl_req_if / ctrl_rsp_if
// Valid/ready channels of the credential table: request bytes in, one
// result item per finished request out.
// ----------------------------------------------------------------------------
interface ctrl_req_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] char_byte;

  modport source (output valid, output action, output char_byte, input ready);
  modport sink   (input valid, input action, input char_byte, output ready);
endinterface

interface ctrl_rsp_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic [2:0] status;
  logic [6:0] user_count;

  modport source (output valid, output ok, output status, output user_count,
                  input ready);
  modport sink   (input valid, input ok, input status, input user_count,
                  output ready);
endinterface

/* rtl/credential_table_register_login.sv */
// ----------------------------------------------------------------------------
// credential_table_register_login
// Credential table with djb2 password hashes, fed one request byte at a time.
// ----------------------------------------------------------------------------
// Requests arrive as bytes: the user name, a zero byte, the password and a
// zero byte; action is sampled on that last zero byte, which alone yields a
// result item. Every other byte is taken whenever the sequencer is idle. On
// the final zero byte the input stalls while one byte comparator walks the
// stored entries through the name RAM read port: a check state, then for
// each scanned entry an entry read and a length compare, then one compare
// per name byte while the lengths agree; a miss passes through S_MISS, and
// a successful register then writes each stored name byte. The input also
// stays stalled while the new result waits for the output register to free
// up. The result register lets name and password bytes of the next request
// flow in while a result waits to be taken.
// ----------------------------------------------------------------------------
module credential_table_register_login #(
  parameter int unsigned USER_SLOTS       = 64,
  parameter int unsigned NAME_FIELD_BYTES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctrl_req_if.sink   req_i,
  ctrl_rsp_if.source rsp_o
);
  import ctrl_pkg::*;

  localparam int unsigned KEEP   = NAME_FIELD_BYTES - 1;
  localparam int unsigned LEN_W  = $clog2(NAME_FIELD_BYTES + 1);
  localparam int unsigned BIDX_W = (KEEP > 1) ? $clog2(KEEP) : 1;

  logic              fire;
  logic              final_byte;
  logic              idle;
  logic              clear;
  logic [BIDX_W-1:0] buf_idx;
  logic [7:0]        buf_byte;
  logic [LEN_W-1:0]  name_len;
  logic              pw_nonempty;
  logic [31:0]       hash;
  logic              res_valid;
  result_t           res;
  logic              res_take;
  logic              out_valid_q, out_valid_d;
  result_t           res_q;

  assign req_i.ready = idle;
  assign fire        = req_i.valid && idle;

  ctrl_collect #(
    .NAME_FIELD_BYTES (NAME_FIELD_BYTES)
  ) u_collect (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .char_i        (req_i.char_byte),
    .clear_i       (clear),
    .buf_idx_i     (buf_idx),
    .buf_byte_o    (buf_byte),
    .final_o       (final_byte),
    .name_len_o    (name_len),
    .pw_nonempty_o (pw_nonempty),
    .hash_o        (hash)
  );

  ctrl_engine #(
    .USER_SLOTS       (USER_SLOTS),
    .NAME_FIELD_BYTES (NAME_FIELD_BYTES)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (final_byte),
    .action_i      (action_e'(req_i.action)),
    .name_len_i    (name_len),
    .pw_nonempty_i (pw_nonempty),
    .hash_i        (hash),
    .buf_idx_o     (buf_idx),
    .buf_byte_i    (buf_byte),
    .idle_o        (idle),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_take_i    (res_take),
    .clear_o       (clear)
  );

  // output register, refilled as soon as the previous item leaves
  assign res_take = res_valid && (!out_valid_q || rsp_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      res_q <= res;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.ok         = res_q.ok;
  assign rsp_o.status     = res_q.status;
  assign rsp_o.user_count = res_q.user_count;

endmodule

/* rtl/ctrl_ram.sv */
// ----------------------------------------------------------------------------
// ctrl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ctrl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ctrl_collect.sv */
// ----------------------------------------------------------------------------
// ctrl_collect
// Request collector: buffers name bytes, counts the name length and folds
// password bytes into the running djb2 hash.
// ----------------------------------------------------------------------------
module ctrl_collect #(
  parameter int unsigned NAME_FIELD_BYTES = 32,
  localparam int unsigned KEEP   = NAME_FIELD_BYTES - 1,
  localparam int unsigned LEN_W  = $clog2(NAME_FIELD_BYTES + 1),
  localparam int unsigned BIDX_W = (KEEP > 1) ? $clog2(KEEP) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        char_i,
  input  logic              clear_i,
  input  logic [BIDX_W-1:0] buf_idx_i,
  output logic [7:0]        buf_byte_o,
  output logic              final_o,
  output logic [LEN_W-1:0]  name_len_o,
  output logic              pw_nonempty_o,
  output logic [31:0]       hash_o
);
  import ctrl_pkg::*;

  logic              in_pw_q, in_pw_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              pw_ne_q, pw_ne_d;
  logic [31:0]       hash_q, hash_d;
  logic [7:0]        buf_q [KEEP];
  logic              buf_we;

  always_comb begin
    in_pw_d = in_pw_q;
    len_d   = len_q;
    pw_ne_d = pw_ne_q;
    hash_d  = hash_q;
    buf_we  = 1'b0;
    if (clear_i) begin
      in_pw_d = 1'b0;
      len_d   = '0;
      pw_ne_d = 1'b0;
      hash_d  = HASH_SEED;
    end else if (fire_i) begin
      if (!in_pw_q) begin
        if (char_i == 8'd0) begin
          in_pw_d = 1'b1;
        end else begin
          buf_we = (len_q < LEN_W'(KEEP));
          if (len_q < LEN_W'(NAME_FIELD_BYTES)) begin
            len_d = len_q + LEN_W'(1);
          end
        end
      end else if (char_i != 8'd0) begin
        // hash * 33 + byte
        hash_d  = (hash_q << 5) + hash_q + {24'd0, char_i};
        pw_ne_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pw_q <= 1'b0;
      len_q   <= '0;
      pw_ne_q <= 1'b0;
      hash_q  <= HASH_SEED;
    end else begin
      in_pw_q <= in_pw_d;
      len_q   <= len_d;
      pw_ne_q <= pw_ne_d;
      hash_q  <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_q[len_q[BIDX_W-1:0]] <= char_i;
    end
  end

  assign buf_byte_o    = buf_q[buf_idx_i];
  assign final_o       = fire_i && in_pw_q && (char_i == 8'd0);
  assign name_len_o    = len_q;
  assign pw_nonempty_o = pw_ne_q;
  assign hash_o        = hash_q;

endmodule

/* rtl/ctrl_engine.sv */
// ----------------------------------------------------------------------------
// ctrl_engine
// Table sequencer: walks the stored entries with one byte comparator over
// the name RAM, then appends a new entry or checks the password hash.
// ----------------------------------------------------------------------------
module ctrl_engine #(
  parameter int unsigned USER_SLOTS       = 64,
  parameter int unsigned NAME_FIELD_BYTES = 32,
  localparam int unsigned KEEP    = NAME_FIELD_BYTES - 1,
  localparam int unsigned LEN_W   = $clog2(NAME_FIELD_BYTES + 1),
  localparam int unsigned BIDX_W  = (KEEP > 1) ? $clog2(KEEP) : 1,
  localparam int unsigned SLOT_W  = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1,
  localparam int unsigned CNT_W   = $clog2(USER_SLOTS + 1),
  localparam int unsigned BYTES   = USER_SLOTS * KEEP,
  localparam int unsigned BA_W    = (BYTES > 1) ? $clog2(BYTES) : 1,
  localparam int unsigned ENT_W   = 32 + LEN_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  ctrl_pkg::action_e     action_i,
  input  logic [LEN_W-1:0]      name_len_i,
  input  logic                  pw_nonempty_i,
  input  logic [31:0]           hash_i,
  output logic [BIDX_W-1:0]     buf_idx_o,
  input  logic [7:0]            buf_byte_i,
  output logic                  idle_o,
  output logic                  res_valid_o,
  output ctrl_pkg::result_t     res_o,
  input  logic                  res_take_i,
  output logic                  clear_o
);
  import ctrl_pkg::*;

  state_e            state_q, state_d;
  action_e           act_q, act_d;
  status_e           status_q, status_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [BA_W-1:0]   base_q, base_d;
  logic [BA_W-1:0]   ba_q, ba_d;
  logic [BA_W-1:0]   next_base_q, next_base_d;
  logic [BIDX_W-1:0] j_q, j_d;
  logic [CNT_W-1:0]  count_q, count_d;

  logic              ent_we, ent_re;
  logic [ENT_W-1:0]  ent_rdata;
  logic [LEN_W-1:0]  ent_len;
  logic [31:0]       ent_hash;
  logic              byte_we, byte_re;
  logic [BA_W-1:0]   byte_raddr;
  logic [7:0]        byte_rdata;
  logic [LEN_W-1:0]  keep_len;
  logic              overlong;
  logic              step_slot;
  logic              found;

  assign ent_len  = ent_rdata[ENT_W-1:32];
  assign ent_hash = ent_rdata[31:0];
  assign overlong = (name_len_i == LEN_W'(NAME_FIELD_BYTES));
  assign keep_len = overlong ? LEN_W'(KEEP) : name_len_i;

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    status_d    = status_q;
    slot_d      = slot_q;
    base_d      = base_q;
    ba_d        = ba_q;
    next_base_d = next_base_q;
    j_d         = j_q;
    count_d     = count_q;
    ent_we      = 1'b0;
    ent_re      = 1'b0;
    byte_we     = 1'b0;
    byte_re     = 1'b0;
    byte_raddr  = ba_q;
    step_slot   = 1'b0;
    found       = 1'b0;
    res_valid_o = 1'b0;
    clear_o     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          act_d   = action_i;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        slot_d = '0;
        base_d = '0;
        priority if (act_q == ACT_REGISTER &&
                     (name_len_i == '0 || !pw_nonempty_i)) begin
          status_d = ST_EMPTY;
          state_d  = S_DONE;
        end else if (act_q == ACT_REGISTER &&
                     count_q == CNT_W'(USER_SLOTS)) begin
          status_d = ST_FULL;
          state_d  = S_DONE;
        end else if (overlong || count_q == '0) begin
          // an overlong name never matches a stored one
          state_d = S_MISS;
        end else begin
          state_d = S_RD_ENTRY;
        end
      end
      S_RD_ENTRY: begin
        ent_re  = 1'b1;
        state_d = S_CMP_LEN;
      end
      S_CMP_LEN: begin
        if (ent_len == name_len_i) begin
          byte_re    = 1'b1;
          byte_raddr = base_q;
          ba_d       = base_q;
          j_d        = '0;
          state_d    = S_CMP_BYTE;
        end else begin
          step_slot = 1'b1;
        end
      end
      S_CMP_BYTE: begin
        if (byte_rdata != buf_byte_i) begin
          step_slot = 1'b1;
        end else if (LEN_W'(j_q) == name_len_i - LEN_W'(1)) begin
          found = 1'b1;
        end else begin
          byte_re    = 1'b1;
          byte_raddr = ba_q + BA_W'(1);
          ba_d       = ba_q + BA_W'(1);
          j_d        = j_q + BIDX_W'(1);
        end
      end
      S_MISS: begin
        if (act_q == ACT_LOGIN) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_DONE;
        end else begin
          ent_we  = 1'b1;
          ba_d    = next_base_q;
          j_d     = '0;
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        byte_we = 1'b1;
        if (LEN_W'(j_q) == keep_len - LEN_W'(1)) begin
          count_d     = count_q + CNT_W'(1);
          next_base_d = next_base_q + BA_W'(KEEP);
          status_d    = ST_OK;
          state_d     = S_DONE;
        end else begin
          ba_d = ba_q + BA_W'(1);
          j_d  = j_q + BIDX_W'(1);
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          clear_o = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (found) begin
      state_d = S_DONE;
      if (act_q == ACT_REGISTER) begin
        status_d = ST_TAKEN;
      end else begin
        status_d = (ent_hash == hash_i) ? ST_OK : ST_WRONG_PW;
      end
    end

    if (step_slot) begin
      slot_d = slot_q + SLOT_W'(1);
      base_d = base_q + BA_W'(KEEP);
      if (CNT_W'(slot_q) + CNT_W'(1) == count_q) begin
        state_d = S_MISS;
      end else begin
        state_d = S_RD_ENTRY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= ACT_REGISTER;
      status_q    <= ST_OK;
      slot_q      <= '0;
      base_q      <= '0;
      ba_q        <= '0;
      next_base_q <= '0;
      j_q         <= '0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      status_q    <= status_d;
      slot_q      <= slot_d;
      base_q      <= base_d;
      ba_q        <= ba_d;
      next_base_q <= next_base_d;
      j_q         <= j_d;
      count_q     <= count_d;
    end
  end

  // entry length and hash, one word per slot
  ctrl_ram #(
    .WIDTH (ENT_W),
    .DEPTH (USER_SLOTS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (count_q[SLOT_W-1:0]),
    .wdata_i ({keep_len, hash_i}),
    .re_i    (ent_re),
    .raddr_i (slot_q),
    .rdata_o (ent_rdata)
  );

  // name bytes, KEEP bytes per slot
  ctrl_ram #(
    .WIDTH (8),
    .DEPTH (BYTES)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (byte_we),
    .waddr_i (ba_q),
    .wdata_i (buf_byte_i),
    .re_i    (byte_re),
    .raddr_i (byte_raddr),
    .rdata_o (byte_rdata)
  );

  assign buf_idx_o = j_q;
  assign idle_o    = (state_q == S_IDLE);
  assign res_o     = '{ok:         (status_q == ST_OK),
                       status:     status_q,
                       user_count: USER_COUNT_W'(count_q)};

endmodule

/* rtl/ctrl_checker.sv */
// ----------------------------------------------------------------------------
// ctrl_checker
// Port-level checks of the credential table: result hold, input stall after
// a request ends, user count steps and ok/status agreement.
// ----------------------------------------------------------------------------
module ctrl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [7:0] in_char_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_ok_i,
  input logic [2:0] out_status_i,
  input logic [6:0] out_count_i
);
  import ctrl_pkg::*;

  logic       in_fire;
  logic       out_fire;
  logic       pw_phase_q;
  logic [6:0] last_count_q;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // zero bytes alternate between ending the name and ending the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_phase_q   <= 1'b0;
      last_count_q <= '0;
    end else begin
      if (in_fire && in_char_i == 8'd0) begin
        pw_phase_q <= !pw_phase_q;
      end
      if (out_fire) begin
        last_count_q <= out_count_i;
      end
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_busy_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_char_i == 8'd0 && pw_phase_q |=> !in_ready_i)
    else $error("input taken while table search is pending");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> (out_count_i == last_count_q ||
                  out_count_i == last_count_q + 7'd1))
    else $error("user count jumped between results");

  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_ok_i == (out_status_i == ST_OK)))
    else $error("ok flag disagrees with status");

endmodule

bind credential_table_register_login ctrl_checker u_ctrl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .in_char_i    (req_i.char_byte),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .out_ok_i     (rsp_o.ok),
  .out_status_i (rsp_o.status),
  .out_count_i  (rsp_o.user_count)
);
